/* rtl/mas_pkg.sv */
// Shared types, codes and widths for the multi alarm scheduler.
package mas_pkg;

    localparam int TIME_W      = 34;
    localparam int TRIG_W      = TIME_W + 1;
    localparam int ID_W        = 16;
    localparam int DELAY_W     = 32;
    localparam int RID_W       = 17;
    localparam int REP_W       = 4;
    localparam int CNT_OUT_W   = 6;
    localparam int MAXEN_W     = 6;
    localparam int CNT_EXT_W   = 9;
    localparam int SLOTS_DEF   = 32;
    localparam int IN_DATA_W   = 88;
    localparam int OUT_DATA_W  = 56;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 5;

    localparam logic [MAXEN_W-1:0] MAX_EN_RST    = 6'd20;
    localparam logic [REP_W-1:0]   REP_LIMIT_RST = 4'd10;
    localparam logic [TIME_W-1:0]  SYNC_RST      = 34'd1734480000;
    localparam logic [REP_W-1:0]   REP_SAT       = 4'd15;

    localparam logic [1:0] REG_MAX_EN    = 2'd0;
    localparam logic [1:0] REG_REP_LIMIT = 2'd1;
    localparam logic [1:0] REG_SYNC      = 2'd2;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_SET     = 3'd1;
    localparam logic [OP_W-1:0] OP_CANCEL  = 3'd2;
    localparam logic [OP_W-1:0] OP_DISMISS = 3'd3;
    localparam logic [OP_W-1:0] OP_REPEAT  = 3'd4;
    localparam logic [OP_W-1:0] OP_LED     = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SEC  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_ID    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_A,
        S_EXEC,
        S_SCAN_B,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic start_scan;
        logic exec;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

/* rtl/mas_ram.sv */
// Generic single write port RAM with registered read.
module mas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

/* rtl/mas_ctrl.sv */
// Controller state machine: sequences the two slot scans, the update and the result load of one item.
module mas_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mas_pkg::t_sts i_sts,
    output mas_pkg::t_cmd o_cmd
);
    import mas_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_SCAN_A;
            S_SCAN_A: if (i_sts.scan_done) n_state = S_EXEC;
            S_EXEC:   n_state = S_SCAN_B;
            S_SCAN_B: if (i_sts.scan_done) n_state = S_FINISH;
            S_FINISH: if (i_sts.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready       = i_rst_n;
                o_cmd.capture    = i_rst_n && i_in_valid;
                o_cmd.start_scan = i_rst_n && i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec       = 1'b1;
                o_cmd.start_scan = 1'b1;
            end
            S_FINISH: o_cmd.load_out = i_sts.out_free;
            default: ;
        endcase
    end

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready) else $error("ready while busy");
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_SCAN_A)) else $error("no scan");
    a_exec_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_SCAN_B)) else $error("exec not single");
endmodule

/* rtl/mas_dp.sv */
// Datapath: slot table, scan accumulators, alarm state and result register.
module mas_dp #(
    parameter int SLOT_COUNT = mas_pkg::SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mas_pkg::t_cmd                   i_cmd,
    output mas_pkg::t_sts                   o_sts,
    input  logic [mas_pkg::OP_W-1:0]        i_op,
    input  logic [mas_pkg::TIME_W-1:0]      i_now,
    input  logic [mas_pkg::DELAY_W-1:0]     i_delay,
    input  logic [mas_pkg::ID_W-1:0]        i_target,
    input  logic [mas_pkg::MAXEN_W-1:0]     i_max_en,
    input  logic [mas_pkg::REP_W-1:0]       i_rep_limit,
    input  logic [mas_pkg::TIME_W-1:0]      i_sync_floor,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [mas_pkg::STATUS_W-1:0]    o_out_user,
    output logic [mas_pkg::OUT_DATA_W-1:0]  o_out_data
);
    import mas_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);
    localparam int MW = TRIG_W + ID_W;

    // latched item
    logic [OP_W-1:0]    r_op;
    logic [TIME_W-1:0]  r_now;
    logic [DELAY_W-1:0] r_delay;
    logic [ID_W-1:0]    r_target;

    // scan control
    logic [IW-1:0] r_idx, r_rd_idx;
    logic          r_issue, r_rd_vld, r_pass_b;

    // table and alarm state
    logic [SLOT_COUNT-1:0] r_en;
    logic [ID_W-1:0]       r_next_id;
    logic                  r_ringing, r_led;
    logic [RID_W-1:0]      r_ring_id;
    logic [REP_W-1:0]      r_rep;

    // pass A findings
    logic            r_due_f, r_free_f, r_match_f;
    logic [IW-1:0]   r_due_idx, r_free_idx, r_match_idx;
    logic [ID_W-1:0] r_due_id;
    logic [CW-1:0]   r_cnt_a, r_cnt_en, r_cnt_up;

    // per-item result
    logic [STATUS_W-1:0] r_status;
    logic [ID_W-1:0]     r_rid;
    logic                r_fired, r_sound;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_user;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [MW-1:0]     ram_wdata, ram_q;
    logic [TRIG_W-1:0] q_trig;
    logic [ID_W-1:0]   q_id;
    logic              q_en, unsynced;
    logic [TRIG_W-1:0] new_trig;
    logic [TIME_W-1:0] set_base;
    logic [REP_W-1:0]  rep_inc;

    assign q_trig   = ram_q[MW-1 -: TRIG_W];
    assign q_id     = ram_q[ID_W-1:0];
    assign q_en     = r_en[r_rd_idx];
    assign unsynced = r_now < i_sync_floor;
    assign set_base = unsynced ? '0 : r_now;
    assign new_trig = {1'b0, set_base} + TRIG_W'(r_delay);
    assign rep_inc  = (r_rep < REP_SAT) ? r_rep + 1'b1 : r_rep;

    assign o_sts.scan_done = r_rd_vld && (r_rd_idx == LAST);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // write a new alarm only on a successful set
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_free_idx;
        ram_wdata = {new_trig, r_next_id};
        if (i_cmd.exec && r_op == OP_SET
            && (CNT_EXT_W'(r_cnt_a) < CNT_EXT_W'(i_max_en)) && r_free_f
            && r_delay != '0 && !r_delay[DELAY_W-1]) begin
            ram_we = 1'b1;
        end
    end

    mas_ram #(.WIDTH(MW), .DEPTH(SLOT_COUNT), .AW(IW)) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_now    <= i_now;
            r_delay  <= i_delay;
            r_target <= i_target;
        end
    end

    // scan sequencing and accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_idx    <= '0;
            r_rd_idx <= '0;
            r_pass_b <= 1'b0;
        end else begin
            r_rd_vld <= r_issue;
            r_rd_idx <= r_idx;
            if (i_cmd.start_scan) begin
                r_idx    <= '0;
                r_issue  <= 1'b1;
                r_pass_b <= i_cmd.exec;
            end else if (r_issue) begin
                if (r_idx == LAST) begin
                    r_issue <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_scan) begin
            r_cnt_en <= '0;
            r_cnt_up <= '0;
            if (!i_cmd.exec) begin
                r_due_f   <= 1'b0;
                r_free_f  <= 1'b0;
                r_match_f <= 1'b0;
                r_cnt_a   <= '0;
            end
        end else if (r_rd_vld) begin
            if (r_pass_b) begin
                if (q_en) begin
                    r_cnt_en <= r_cnt_en + 1'b1;
                    if (q_trig > {1'b0, r_now}) r_cnt_up <= r_cnt_up + 1'b1;
                end
            end else begin
                if (q_en) r_cnt_a <= r_cnt_a + 1'b1;
                if (q_en && !r_due_f && {1'b0, r_now} >= q_trig) begin
                    r_due_f   <= 1'b1;
                    r_due_idx <= r_rd_idx;
                    r_due_id  <= q_id;
                end
                if (!q_en && !r_free_f) begin
                    r_free_f   <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
                if (q_en && !r_match_f && q_id == r_target) begin
                    r_match_f   <= 1'b1;
                    r_match_idx <= r_rd_idx;
                end
            end
        end
    end

    // apply the operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en      <= '0;
            r_next_id <= ID_W'(1);
            r_ringing <= 1'b0;
            r_ring_id <= '1;
            r_rep     <= '0;
            r_led     <= 1'b0;
        end else if (i_cmd.exec) begin
            r_status <= ST_OK;
            r_rid    <= '0;
            r_fired  <= 1'b0;
            r_sound  <= 1'b0;
            case (r_op)
                OP_TICK: begin
                    if (r_ringing || unsynced) begin
                        r_status <= ST_IGNORED;
                    end else if (r_due_f) begin
                        r_ringing          <= 1'b1;
                        r_ring_id          <= {1'b0, r_due_id};
                        r_rep              <= '0;
                        r_led              <= 1'b1;
                        r_en[r_due_idx]    <= 1'b0;
                        r_fired            <= 1'b1;
                        r_sound            <= 1'b1;
                        r_rid              <= r_due_id;
                    end
                end
                OP_SET: begin
                    if (CNT_EXT_W'(r_cnt_a) >= CNT_EXT_W'(i_max_en) || !r_free_f) begin
                        r_status <= ST_TOO_MANY;
                    end else begin
                        r_next_id <= r_next_id + 1'b1;
                        if (r_delay == '0 || r_delay[DELAY_W-1]) begin
                            r_status <= ST_BAD_SEC;
                        end else begin
                            r_en[r_free_idx] <= 1'b1;
                            r_rid            <= r_next_id;
                        end
                    end
                end
                OP_CANCEL: begin
                    if (r_match_f) r_en[r_match_idx] <= 1'b0;
                    else r_status <= ST_NO_ID;
                end
                OP_DISMISS: begin
                    if (r_ringing) begin
                        r_ringing <= 1'b0;
                        r_ring_id <= '1;
                    end else begin
                        r_status <= ST_IGNORED;
                    end
                end
                OP_REPEAT: begin
                    if (!r_ringing) begin
                        r_status <= ST_IGNORED;
                    end else begin
                        r_rep <= rep_inc;
                        if (rep_inc >= i_rep_limit) begin
                            r_ringing <= 1'b0;
                            r_ring_id <= '1;
                        end else begin
                            r_sound <= 1'b1;
                        end
                    end
                end
                OP_LED: begin
                    if (r_ringing) r_led <= !r_led;
                    else r_status <= ST_IGNORED;
                end
                default: r_status <= ST_IGNORED;
            endcase
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_user <= r_status;
            r_out_data <= {2'b00,
                           CNT_OUT_W'(r_cnt_up),
                           CNT_OUT_W'(r_cnt_en),
                           r_ringing ? r_rep : {REP_W{1'b0}},
                           r_ring_id,
                           r_ringing,
                           r_ringing & r_led,
                           r_sound,
                           r_ringing,
                           r_fired,
                           r_rid};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_user  = r_out_user;
    assign o_out_data  = r_out_data;

    a_idle_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ringing |-> (r_ring_id == {RID_W{1'b1}})) else $error("stale ringing id");
    a_ring_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ringing |-> !r_ring_id[RID_W-1]) else $error("ringing without id");
endmodule

/* rtl/multi_alarm_scheduler.sv */
// Top level of the multi alarm scheduler: ports, config registers, controller and datapath.
//
// Usage: commands enter as beats on the s_axis channel (tuser = operation, tdata = now_time,
// delay_seconds, target_id) and each produces exactly one result beat on m_axis
// (tuser = status, tdata = result id, flags, ringing id, repeat count, slot counts).
// Configuration (max_enabled, repeat_limit, sync_floor) is written through the APB port
// at byte addresses 0, 8 and 16; the user must write it only while no command is in
// flight, as the block itself does not enforce this; reads return the values. Each command
// makes two passes over the slot table, one slot read per cycle from the slot RAM: a search
// pass (due slot, free slot, id match, enabled count) and, after the update cycle, a count
// pass (enabled and upcoming slots). One command is in work at a time: a new command is not
// accepted before the current one has loaded its result register.
// Reset clears all enables, the ringing state and the result valid flag, sets the next id
// to one and loads the config defaults; s_axis_tready stays low while reset is held.
// The result sits in an output register; if the receiver stalls it holds there, the next
// command can be accepted and is finished up to its result, which then waits until the
// earlier beat is taken.
module multi_alarm_scheduler #(
    parameter int SLOT_COUNT = mas_pkg::SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] operation
    input  logic [mas_pkg::OP_W-1:0]           s_axis_tuser,
    // [33:0] now_time, [65:34] delay_seconds, [81:66] target_id, [87:82] zero
    input  logic [mas_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // master stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [2:0] status
    output logic [mas_pkg::STATUS_W-1:0]       m_axis_tuser,
    // [15:0] result_id, [16] fired, [17] motor_on, [18] sound_request, [19] led_phase,
    // [20] ringing, [37:21] ringing_id, [41:38] repeats_done, [47:42] enabled slots,
    // [53:48] upcoming slots, [55:54] zero
    output logic [mas_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mas_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [mas_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [mas_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import mas_pkg::*;

    t_cmd cmd;
    t_sts sts;

    logic [MAXEN_W-1:0] r_max_en;
    logic [REP_W-1:0]   r_rep_limit;
    logic [TIME_W-1:0]  r_sync_floor;
    logic [1:0]         reg_sel;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // config registers, written on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_en     <= MAX_EN_RST;
            r_rep_limit  <= REP_LIMIT_RST;
            r_sync_floor <= SYNC_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_MAX_EN:    r_max_en     <= pwdata[MAXEN_W-1:0];
                REG_REP_LIMIT: r_rep_limit  <= pwdata[REP_W-1:0];
                REG_SYNC:      r_sync_floor <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_MAX_EN:    prdata = CFG_DATA_W'(r_max_en);
            REG_REP_LIMIT: prdata = CFG_DATA_W'(r_rep_limit);
            REG_SYNC:      prdata = CFG_DATA_W'(r_sync_floor);
            default:       prdata = '0;
        endcase
    end

    mas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mas_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (s_axis_tuser),
        .i_now        (s_axis_tdata[TIME_W-1:0]),
        .i_delay      (s_axis_tdata[TIME_W+DELAY_W-1:TIME_W]),
        .i_target     (s_axis_tdata[TIME_W+DELAY_W+ID_W-1:TIME_W+DELAY_W]),
        .i_max_en     (r_max_en),
        .i_rep_limit  (r_rep_limit),
        .i_sync_floor (r_sync_floor),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_user   (m_axis_tuser),
        .o_out_data   (m_axis_tdata)
    );
endmodule
